[design/rrq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrq_pkg - shared definitions for the round-robin ready queue
// Sizes, request and status codes, sequencer states and helpers.
// ----------------------------------------------------------------------------
package rrq_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_W      = PTR_W + 1;       // bank bit above the slot
   localparam int TASK_COUNT  = 256;
   localparam int TASK_W      = $clog2(TASK_COUNT);
   localparam int ID_W        = 8;
   localparam int SLICE_W     = 16;

   typedef enum logic [2:0] {
      OP_ADD     = 3'd0,
      OP_REMOVE  = 3'd1,
      OP_SET_RUN = 3'd2,
      OP_YIELD   = 3'd3,
      OP_TICK    = 3'd4
   } op_code_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_DUP  = 2'd2
   } status_code_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_ADD_RD,
      S_ADD_EV,
      S_ADD_FIN,
      S_REM_RD,
      S_REM_EV,
      S_YLD_RD,
      S_YLD_RUN,
      S_YLD_EV,
      S_DONE
   } state_type;

   // ids at or beyond the task count have no runnable bit
   function automatic logic task_ok(input logic [ID_W-1:0] id);
      return int'(id) < TASK_COUNT;
   endfunction

endpackage

[design/rrq_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrq_ram - ring storage, two banks of queue slots
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rrq_ram (
   input  logic                        clock,
   input  logic                        we,
   input  logic [rrq_pkg::ADDR_W-1:0]  waddr,
   input  logic [rrq_pkg::ID_W-1:0]    wdata,
   input  logic [rrq_pkg::ADDR_W-1:0]  raddr,
   output logic [rrq_pkg::ID_W-1:0]    rdata
);

   logic [rrq_pkg::ID_W-1:0] mem [2*rrq_pkg::QUEUE_DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

[design/round_robin_ready_queue_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_ready_queue_core - round-robin ready queue scheduler
// Ring of task ids with add, remove, set-runnable, yield and tick requests.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  req       in         req_valid / req_stall      req_type, req_task_id,
//                                                  req_runnable_in
//  rsp       out        rsp_valid / rsp_stall      rsp_status, rsp_switched,
//                                                  rsp_next_id, rsp_queue_count
//  csr       in         csr_wr_en                  csr_wr_data (slice_ticks)
//
//  Items that touch no ring entry go straight from accept to the result.
//  Add reads and evaluates each queued entry, then appends; remove reads and evaluates each.
//  Yield and yielding ticks visit entries in steps of ring read, runnable read, evaluate.
//  At most one item is in work; req_stall is high until its result is registered.
//  Reset is synchronous; head and count are cleared, the ring RAM is not, and a
//  pass over all 256 runnable bits clears them with req_stall high. A waiting result
//  does not block the next request.
// ----------------------------------------------------------------------------
module round_robin_ready_queue_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [2:0]                    req_type,
   input  logic [rrq_pkg::ID_W-1:0]      req_task_id,
   input  logic                          req_runnable_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_switched,
   output logic [rrq_pkg::ID_W-1:0]      rsp_next_id,
   output logic [rrq_pkg::CNT_W-1:0]     rsp_queue_count,
   input  logic                          csr_wr_en,
   input  logic [rrq_pkg::SLICE_W-1:0]   csr_wr_data
);

   rrq_pkg::state_type              state_ff, state_in;
   rrq_pkg::op_code_type            op_ff, op_in;
   logic [rrq_pkg::ID_W-1:0]        id_ff, id_in;
   logic [rrq_pkg::PTR_W-1:0]       head_ff, head_in;
   logic [rrq_pkg::CNT_W-1:0]       count_ff, count_in;
   logic                            bank_ff, bank_in;
   logic [rrq_pkg::CNT_W-1:0]       idx_ff, idx_in;
   logic [rrq_pkg::CNT_W-1:0]       kept_ff, kept_in;
   logic [rrq_pkg::TASK_W-1:0]      clr_ff, clr_in;
   logic [rrq_pkg::ID_W-1:0]        cur_ff, cur_in;
   logic                            cur_valid_ff, cur_valid_in;
   logic [rrq_pkg::SLICE_W-1:0]     phase_ff, phase_in;
   logic [rrq_pkg::SLICE_W-1:0]     slice_ff;
   rrq_pkg::status_code_type        res_status_ff, res_status_in;
   logic                            res_sw_ff, res_sw_in;
   logic [rrq_pkg::ID_W-1:0]        res_id_ff, res_id_in;

   logic                            rsp_valid_ff;
   logic [1:0]                      rsp_status_ff;
   logic                            rsp_switched_ff;
   logic [rrq_pkg::ID_W-1:0]        rsp_next_id_ff;
   logic [rrq_pkg::CNT_W-1:0]       rsp_queue_count_ff;

   logic                            ram_we;
   logic [rrq_pkg::ADDR_W-1:0]      ram_waddr, ram_raddr;
   logic [rrq_pkg::ID_W-1:0]        ram_wdata, ram_rdata;

   logic                            ready_mem [rrq_pkg::TASK_COUNT];
   logic                            ready_rd_ff;
   logic                            ready_we;
   logic [rrq_pkg::TASK_W-1:0]      ready_waddr, ready_raddr;
   logic                            ready_wdata;

   logic                            req_take;
   logic                            rsp_load;
   logic [rrq_pkg::PTR_W-1:0]       walk_slot;
   logic [rrq_pkg::CNT_W-1:0]       idx_inc;
   logic [rrq_pkg::SLICE_W-1:0]     phase_next, slice_limit;
   logic                            tick_fire;
   logic                            pop_ready;

   assign req_take  = req_valid && !req_stall;
   assign req_stall = (state_ff != rrq_pkg::S_IDLE);
   assign rsp_load  = (state_ff == rrq_pkg::S_DONE) && (!rsp_valid_ff || !rsp_stall);

   // shared walk unit: slot under the cursor and cursor advance
   assign walk_slot = head_ff + idx_ff[rrq_pkg::PTR_W-1:0];
   assign idx_inc   = idx_ff + rrq_pkg::CNT_W'(1);

   assign phase_next  = phase_ff + rrq_pkg::SLICE_W'(1);
   assign slice_limit = (slice_ff == '0) ? rrq_pkg::SLICE_W'(1) : slice_ff;
   assign tick_fire   = (phase_next >= slice_limit) || (phase_next == '0);

   // runnable bit of the popped id, read in the cycle after the ring entry
   assign ready_raddr = ram_rdata[rrq_pkg::TASK_W-1:0];
   assign pop_ready   = rrq_pkg::task_ok(ram_rdata) && ready_rd_ff;

   rrq_ram u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rrq_pkg::S_CLEAR: begin
            if (clr_ff == rrq_pkg::TASK_W'(rrq_pkg::TASK_COUNT - 1)) begin
               state_in = rrq_pkg::S_IDLE;
            end
         end
         rrq_pkg::S_IDLE: begin
            if (req_take) begin
               case (req_type)
                  rrq_pkg::OP_ADD:
                     state_in = (count_ff != '0) ? rrq_pkg::S_ADD_RD : rrq_pkg::S_ADD_FIN;
                  rrq_pkg::OP_REMOVE:
                     state_in = (count_ff != '0) ? rrq_pkg::S_REM_RD : rrq_pkg::S_DONE;
                  rrq_pkg::OP_YIELD:
                     state_in = (count_ff != '0) ? rrq_pkg::S_YLD_RD : rrq_pkg::S_DONE;
                  rrq_pkg::OP_TICK:
                     state_in = (tick_fire && count_ff != '0) ? rrq_pkg::S_YLD_RD
                                                              : rrq_pkg::S_DONE;
                  default:
                     state_in = rrq_pkg::S_DONE;
               endcase
            end
         end
         rrq_pkg::S_ADD_RD:  state_in = rrq_pkg::S_ADD_EV;
         rrq_pkg::S_ADD_EV: begin
            if (ram_rdata == id_ff) begin
               state_in = rrq_pkg::S_DONE;
            end else if (idx_inc == count_ff) begin
               state_in = rrq_pkg::S_ADD_FIN;
            end else begin
               state_in = rrq_pkg::S_ADD_RD;
            end
         end
         rrq_pkg::S_ADD_FIN: state_in = rrq_pkg::S_DONE;
         rrq_pkg::S_REM_RD:  state_in = rrq_pkg::S_REM_EV;
         rrq_pkg::S_REM_EV:
            state_in = (idx_inc == count_ff) ? rrq_pkg::S_DONE : rrq_pkg::S_REM_RD;
         rrq_pkg::S_YLD_RD:  state_in = rrq_pkg::S_YLD_RUN;
         rrq_pkg::S_YLD_RUN: state_in = rrq_pkg::S_YLD_EV;
         rrq_pkg::S_YLD_EV: begin
            if (pop_ready && (!cur_valid_ff || ram_rdata != cur_ff)) begin
               state_in = rrq_pkg::S_DONE;
            end else if (idx_ff == rrq_pkg::CNT_W'(1)) begin
               state_in = rrq_pkg::S_DONE;          // tries used up
            end else if (!pop_ready && count_ff == rrq_pkg::CNT_W'(1)) begin
               state_in = rrq_pkg::S_DONE;          // ring drained
            end else begin
               state_in = rrq_pkg::S_YLD_RD;
            end
         end
         rrq_pkg::S_DONE: begin
            if (rsp_load) begin
               state_in = rrq_pkg::S_IDLE;
            end
         end
         default: state_in = rrq_pkg::S_IDLE;
      endcase
   end

   // datapath and RAM control
   always_comb begin
      op_in         = op_ff;
      id_in         = id_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      bank_in       = bank_ff;
      idx_in        = idx_ff;
      kept_in       = kept_ff;
      clr_in        = clr_ff;
      cur_in        = cur_ff;
      cur_valid_in  = cur_valid_ff;
      phase_in      = phase_ff;
      res_status_in = res_status_ff;
      res_sw_in     = res_sw_ff;
      res_id_in     = res_id_ff;
      ram_we        = 1'b0;
      ram_waddr     = {bank_ff, walk_slot};
      ram_wdata     = id_ff;
      ram_raddr     = {bank_ff, walk_slot};
      ready_we      = 1'b0;
      ready_waddr   = id_ff[rrq_pkg::TASK_W-1:0];
      ready_wdata   = 1'b0;
      unique case (state_ff)
         rrq_pkg::S_CLEAR: begin
            ready_we    = 1'b1;
            ready_waddr = clr_ff;
            clr_in      = clr_ff + rrq_pkg::TASK_W'(1);
         end
         rrq_pkg::S_IDLE: begin
            if (req_take) begin
               op_in         = rrq_pkg::op_code_type'(req_type);
               id_in         = req_task_id;
               idx_in        = '0;
               kept_in       = '0;
               res_status_in = rrq_pkg::ST_OK;
               res_sw_in     = 1'b0;
               res_id_in     = '0;
               case (req_type)
                  rrq_pkg::OP_SET_RUN: begin
                     ready_we    = rrq_pkg::task_ok(req_task_id);
                     ready_waddr = req_task_id[rrq_pkg::TASK_W-1:0];
                     ready_wdata = req_runnable_in;
                  end
                  rrq_pkg::OP_YIELD: idx_in = count_ff;
                  rrq_pkg::OP_TICK: begin
                     idx_in   = count_ff;
                     phase_in = tick_fire ? '0 : phase_next;
                  end
                  default: ;
               endcase
            end
         end
         rrq_pkg::S_ADD_EV: begin
            if (ram_rdata == id_ff) begin
               res_status_in = rrq_pkg::ST_DUP;
            end
            idx_in = idx_inc;
         end
         rrq_pkg::S_ADD_FIN: begin
            ready_we    = rrq_pkg::task_ok(id_ff);
            ready_wdata = 1'b1;
            if (count_ff == rrq_pkg::CNT_W'(rrq_pkg::QUEUE_DEPTH)) begin
               res_status_in = rrq_pkg::ST_FULL;
            end else begin
               ram_we    = 1'b1;
               ram_waddr = {bank_ff, head_ff + count_ff[rrq_pkg::PTR_W-1:0]};
               count_in  = count_ff + rrq_pkg::CNT_W'(1);
            end
         end
         rrq_pkg::S_REM_EV: begin
            // keep survivors, packed from slot 0 of the other bank
            if (ram_rdata != id_ff) begin
               ram_we    = 1'b1;
               ram_waddr = {~bank_ff, kept_ff[rrq_pkg::PTR_W-1:0]};
               ram_wdata = ram_rdata;
               kept_in   = kept_ff + rrq_pkg::CNT_W'(1);
            end
            idx_in = idx_inc;
            if (idx_inc == count_ff) begin
               bank_in  = ~bank_ff;
               head_in  = '0;
               count_in = (ram_rdata != id_ff) ? kept_ff + rrq_pkg::CNT_W'(1) : kept_ff;
            end
         end
         rrq_pkg::S_YLD_RD: begin
            ram_raddr = {bank_ff, head_ff};
         end
         rrq_pkg::S_YLD_RUN: begin
            // hold the head entry on the read port while its runnable bit is read
            ram_raddr = {bank_ff, head_ff};
         end
         rrq_pkg::S_YLD_EV: begin
            // pop the head; a runnable entry goes back to the tail
            head_in = head_ff + rrq_pkg::PTR_W'(1);
            idx_in  = idx_ff - rrq_pkg::CNT_W'(1);
            if (pop_ready) begin
               ram_we    = 1'b1;
               ram_waddr = {bank_ff, head_ff + count_ff[rrq_pkg::PTR_W-1:0]};
               ram_wdata = ram_rdata;
               if (!cur_valid_ff || ram_rdata != cur_ff) begin
                  cur_in       = ram_rdata;
                  cur_valid_in = 1'b1;
                  res_sw_in    = 1'b1;
                  res_id_in    = ram_rdata;
               end
            end else begin
               count_in = count_ff - rrq_pkg::CNT_W'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rrq_pkg::S_CLEAR;
         head_ff       <= '0;
         count_ff      <= '0;
         bank_ff       <= 1'b0;
         clr_ff        <= '0;
         cur_ff        <= '0;
         cur_valid_ff  <= 1'b0;
         phase_ff      <= '0;
         slice_ff      <= rrq_pkg::SLICE_W'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         bank_ff       <= bank_in;
         clr_ff        <= clr_in;
         cur_ff        <= cur_in;
         cur_valid_ff  <= cur_valid_in;
         phase_ff      <= phase_in;
         if (csr_wr_en) begin
            slice_ff <= csr_wr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      id_ff         <= id_in;
      idx_ff        <= idx_in;
      kept_ff       <= kept_in;
      res_status_ff <= res_status_in;
      res_sw_ff     <= res_sw_in;
      res_id_ff     <= res_id_in;
      if (rsp_load) begin
         rsp_status_ff      <= res_status_ff;
         rsp_switched_ff    <= res_sw_ff;
         rsp_next_id_ff     <= res_id_ff;
         rsp_queue_count_ff <= count_ff;
      end
   end

   // runnable bits, one per task id
   always_ff @(posedge clock) begin
      if (ready_we) begin
         ready_mem[ready_waddr] <= ready_wdata;
      end
      ready_rd_ff <= ready_mem[ready_raddr];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_switched    = rsp_switched_ff;
   assign rsp_next_id     = rsp_next_id_ff;
   assign rsp_queue_count = rsp_queue_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= rrq_pkg::CNT_W'(rrq_pkg::QUEUE_DEPTH))
      else $error("ring count beyond depth");

   a_pick_is_current: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rrq_pkg::S_DONE && res_sw_ff) |-> (cur_valid_ff && cur_ff == res_id_ff))
      else $error("picked id not taken as current task");

   a_requeue_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rrq_pkg::S_YLD_EV && ram_we) |=> count_ff == $past(count_ff))
      else $error("re-queue changed the ring count");

   a_status_add_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && res_status_ff != rrq_pkg::ST_OK) |-> op_ff == rrq_pkg::OP_ADD)
      else $error("add status on a request that is not add");

   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("result presented right after reset");

endmodule
